// ===== src/tbw_pkg.sv =====
// Shared types and constants for the transverse basis core.
// Holds the arctangent table, pipeline depths and the cell record types.
// No dependencies.
package tbw_pkg;

	localparam int CORDIC_STEPS = 32;
	localparam int ATAN_ENTRIES = 40;
	localparam int CRD_STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
	localparam int STEP_W = $clog2(ATAN_ENTRIES);

	// atan(2^-i) in units of 2^-32 degree
	localparam logic [37:0] ATAN_TAB [ATAN_ENTRIES] = '{
		38'd193273528320, 38'd114096026022, 38'd60285206654, 38'd30601712202,
		38'd15360239180, 38'd7687607530, 38'd3844741810, 38'd1922488225,
		38'd961258780, 38'd480631223, 38'd240315841, 38'd120157950,
		38'd60078978, 38'd30039490, 38'd15019745, 38'd7509872,
		38'd3754936, 38'd1877468, 38'd938734, 38'd469367,
		38'd234684, 38'd117342, 38'd58671, 38'd29335,
		38'd14668, 38'd7334, 38'd3667, 38'd1833,
		38'd917, 38'd458, 38'd229, 38'd115,
		38'd57, 38'd29, 38'd14, 38'd7,
		38'd4, 38'd2, 38'd1, 38'd0
	};

	localparam logic [43:0] CRD_GAIN = 44'd667681663043;

	localparam logic [24:0] DEG_FULL = 25'd23592960;
	localparam logic [24:0] DEG_HALF = 25'd11796480;
	localparam logic [24:0] DEG_QUARTER = 25'd5898240;
	localparam logic [24:0] DEG_3QUARTER = 25'd17694720;
	// 2^31 mod DEG_FULL, removes the offset that makes the angle unsigned
	localparam logic [24:0] DEG_OFFSET = 25'd524288;

	localparam logic [30:0] LIMIT_RESET = 31'd1073740750;
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

	localparam int NRM_SQRT_STEPS = 32;
	localparam int NRM_DIV_STEPS = 31;
	localparam int NRM_LAT = NRM_SQRT_STEPS + NRM_DIV_STEPS + 8;
	localparam int NRM_A_DLY = NRM_SQRT_STEPS + 2;
	localparam int NRM_SIDE_DLY = NRM_LAT - 4;

	localparam int CRD_LAT = CRD_STEPS + 6;

	typedef enum logic [1:0] {
		ST_OK,
		ST_ZERO_WAVE,
		ST_FIRST_DEGEN,
		ST_SECOND_DEGEN
	} status_t;

	typedef struct packed {
		logic [63:0] rad;
		logic [35:0] rem;
		logic [31:0] root;
	} sq_t;

	typedef struct packed {
		logic [31:0] n;
		logic [2:0][31:0] rem;
		logic [2:0][30:0] low;
		logic [2:0][30:0] quo;
	} dv_t;

	typedef struct packed {
		logic [43:0] x;
		logic [43:0] y;
		logic [41:0] z;
		logic flip;
	} cr_t;

endpackage

// ===== src/tbw_sqrt_cell.sv =====
// One digit step of the integer square root, two radicand bits per cell.
// Depends on tbw_pkg.
module tbw_sqrt_cell
	import tbw_pkg::*;
(
	input logic clk,
	input sq_t cin,
	output sq_t cout
);

	logic [35:0] rem2;
	logic [35:0] trial;

	always_comb begin
		rem2 = {cin.rem[33:0], cin.rad[63:62]};
		trial = {2'b00, cin.root, 2'b01};
	end

	always_ff @(posedge clk) begin
		cout.rad <= {cin.rad[61:0], 2'b00};
		if (rem2 >= trial) begin
			cout.rem <= rem2 - trial;
			cout.root <= {cin.root[30:0], 1'b1};
		end else begin
			cout.rem <= rem2;
			cout.root <= {cin.root[30:0], 1'b0};
		end
	end

endmodule

// ===== src/tbw_div_cell.sv =====
// One quotient bit of a restoring division, three components sharing a divisor.
// Depends on tbw_pkg.
module tbw_div_cell
	import tbw_pkg::*;
(
	input logic clk,
	input dv_t cin,
	output dv_t cout
);

	logic [2:0][32:0] part;
	logic [2:0] take;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			part[j] = {cin.rem[j], cin.low[j][30]};
			take[j] = (part[j] >= {1'b0, cin.n});
		end
	end

	always_ff @(posedge clk) begin
		cout.n <= cin.n;
		for (int j = 0; j < 3; j++) begin
			if (take[j]) begin
				cout.rem[j] <= 32'(part[j] - {1'b0, cin.n});
			end else begin
				cout.rem[j] <= part[j][31:0];
			end
			cout.low[j] <= {cin.low[j][29:0], 1'b0};
			cout.quo[j] <= {cin.quo[j][29:0], take[j]};
		end
	end

endmodule

// ===== src/tbw_cordic_cell.sv =====
// One CORDIC rotation step; the step number picks shift and arctangent.
// Depends on tbw_pkg.
module tbw_cordic_cell
	import tbw_pkg::*;
(
	input logic clk,
	input logic [STEP_W-1:0] step,
	input cr_t cin,
	output cr_t cout
);

	logic signed [43:0] dx;
	logic signed [43:0] dy;
	logic [41:0] ang;

	always_comb begin
		dx = $signed(cin.y) >>> step;
		dy = $signed(cin.x) >>> step;
		ang = {4'b0000, ATAN_TAB[step]};
	end

	always_ff @(posedge clk) begin
		cout.flip <= cin.flip;
		if (!cin.z[41]) begin
			cout.x <= cin.x - dx;
			cout.y <= cin.y + dy;
			cout.z <= cin.z - ang;
		end else begin
			cout.x <= cin.x + dx;
			cout.y <= cin.y - dy;
			cout.z <= cin.z + ang;
		end
	end

endmodule

// ===== src/tbw_nrm.sv =====
// Vector normalizer to Q1.30: prescale, sum of squares, square root cells,
// division cells. Depends on tbw_pkg and the cells.
module tbw_nrm
	import tbw_pkg::*;
(
	input logic clk,
	input logic [2:0][63:0] vec_in,
	output logic [2:0][31:0] vec_out,
	output logic vec_ok
);

	function automatic logic [5:0] lead_one(input logic [63:0] m);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (m[i]) begin
				p = 6'(i);
			end
		end
		return p;
	endfunction

	logic [2:0][63:0] mag_s1;
	logic [2:0] neg_s1;
	logic [2:0][63:0] a_s2;
	logic [63:0] max_s2;
	logic [2:0] neg_s2;
	logic [2:0][63:0] a_s3;
	logic [63:0] max_s3;
	logic [5:0] lead_s3;
	logic [3:0] side_s3;
	logic [2:0][31:0] a_s4;
	logic [2:0][63:0] sq_s5;
	logic [63:0] sum_s6;
	logic [5:0] sh;
	logic [63:0] top_m;
	logic halve;
	logic [63:0] m_max;

	logic [2:0][31:0] a_dl [NRM_A_DLY];
	logic [3:0] side_dl [NRM_SIDE_DLY];
	sq_t sq_c [NRM_SQRT_STEPS+1];
	dv_t dv_c [NRM_DIV_STEPS+1];
	dv_t dv_s7;
	logic [2:0][61:0] dvd;
	logic [31:0] root;
	logic [3:0] side_d;

	always_comb begin
		m_max = mag_s1[0];
		if (mag_s1[1] > m_max) begin
			m_max = mag_s1[1];
		end
		if (mag_s1[2] > m_max) begin
			m_max = mag_s1[2];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			neg_s1[j] <= vec_in[j][63];
			mag_s1[j] <= vec_in[j][63] ? (64'd0 - vec_in[j]) : vec_in[j];
		end
		a_s2 <= mag_s1;
		max_s2 <= m_max;
		neg_s2 <= neg_s1;
		a_s3 <= a_s2;
		max_s3 <= max_s2;
		lead_s3 <= lead_one(max_s2);
		side_s3 <= {neg_s2, (max_s2 == 64'd0)};
	end

	// bring the largest magnitude into [2^30, 2^31]; one more halving when
	// the truncated top still lies above 2^31
	always_comb begin
		if (lead_s3 >= 6'd31) begin
			sh = lead_s3 - 6'd31;
		end else begin
			sh = 6'd30 - lead_s3;
		end
		top_m = max_s3 >> sh;
		halve = (lead_s3 >= 6'd31) && (top_m[30:0] != 31'd0);
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			if (lead_s3 >= 6'd31) begin
				a_s4[j] <= 32'((a_s3[j] >> sh) >> halve);
			end else begin
				a_s4[j] <= 32'(a_s3[j] << sh);
			end
			sq_s5[j] <= 64'(a_s4[j]) * 64'(a_s4[j]);
		end
		sum_s6 <= sq_s5[0] + sq_s5[1] + sq_s5[2];
	end

	always_ff @(posedge clk) begin
		a_dl[0] <= a_s4;
		for (int i = 1; i < NRM_A_DLY; i++) begin
			a_dl[i] <= a_dl[i-1];
		end
		side_dl[0] <= side_s3;
		for (int i = 1; i < NRM_SIDE_DLY; i++) begin
			side_dl[i] <= side_dl[i-1];
		end
	end

	assign sq_c[0] = '{rad: sum_s6, rem: 36'd0, root: 32'd0};

	for (genvar k = 0; k < NRM_SQRT_STEPS; k++) begin : g_sqrt
		tbw_sqrt_cell u_cell (
			.clk(clk),
			.cin(sq_c[k]),
			.cout(sq_c[k+1])
		);
	end

	assign root = sq_c[NRM_SQRT_STEPS].root;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			dvd[j] = {a_dl[NRM_A_DLY-1][j], 30'd0} + {31'd0, root[31:1]};
		end
	end

	always_ff @(posedge clk) begin
		dv_s7.n <= root;
		for (int j = 0; j < 3; j++) begin
			dv_s7.rem[j] <= {1'b0, dvd[j][61:31]};
			dv_s7.low[j] <= dvd[j][30:0];
			dv_s7.quo[j] <= 31'd0;
		end
	end

	assign dv_c[0] = dv_s7;

	for (genvar k = 0; k < NRM_DIV_STEPS; k++) begin : g_div
		tbw_div_cell u_cell (
			.clk(clk),
			.cin(dv_c[k]),
			.cout(dv_c[k+1])
		);
	end

	assign side_d = side_dl[NRM_SIDE_DLY-1];

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			if (side_d[j+1]) begin
				vec_out[j] <= 32'd0 - {1'b0, dv_c[NRM_DIV_STEPS].quo[j]};
			end else begin
				vec_out[j] <= {1'b0, dv_c[NRM_DIV_STEPS].quo[j]};
			end
		end
		vec_ok <= ~side_d[0];
	end

endmodule

// ===== src/transverse_basis_from_wave_vector_core.sv =====
// Top level: transverse basis from a wave vector, turned by an angle.
// Depends on tbw_pkg, tbw_nrm and tbw_cordic_cell.
//
//  channel   handshake             payload
//  command   start / busy          wave_x wave_y wave_z turn_angle
//  result    done (one cycle)      first_* second_* status
//  limit     parallel_limit_we     parallel_limit_wdata
//
// Fully pipelined: one item per cycle, busy is never raised.
// Three normalizers lie in series, with 32 root cells and 31 divide cells each.
// The angle CORDIC runs beside the first normalizer and waits in a delay line.
// Reset clears the valid line and loads the limit; no clearing pass.
// The receiver cannot stall, so there is no back pressure anywhere.
module transverse_basis_from_wave_vector_core
	import tbw_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [31:0] wave_x,
	input logic signed [31:0] wave_y,
	input logic signed [31:0] wave_z,
	input logic signed [31:0] turn_angle,
	input logic parallel_limit_we,
	input logic [30:0] parallel_limit_wdata,
	output logic done,
	output logic signed [31:0] first_x,
	output logic signed [31:0] first_y,
	output logic signed [31:0] first_z,
	output logic signed [31:0] second_x,
	output logic signed [31:0] second_y,
	output logic signed [31:0] second_z,
	output logic [1:0] status
);

	localparam int K_DLY = NRM_LAT + 2;
	localparam int ST_DLY = NRM_LAT + 1;
	localparam int CS_DLY = 3 * NRM_LAT + 4 - CRD_LAT;
	localparam int VLD_LEN = 3 * NRM_LAT + 8;
	localparam logic [10:0] RECIP_45 = 11'd1456;
	localparam logic [12:0] BLOCK_45 = 13'd45;

	function automatic logic [31:0] q30_round(input logic [63:0] v);
		logic [63:0] m;
		logic [33:0] r;
		logic [31:0] s;
		m = v[63] ? (64'd0 - v) : v;
		m = m + 64'h2000_0000;
		r = m[63:30];
		s = (r > {2'b00, ONE_Q30}) ? ONE_Q30 : r[31:0];
		return v[63] ? (32'd0 - s) : s;
	endfunction

	logic [30:0] limit_q;
	logic [VLD_LEN-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			vld_q <= '0;
		end else begin
			if (parallel_limit_we) begin
				limit_q <= parallel_limit_wdata;
			end
			vld_q <= {vld_q[VLD_LEN-2:0], start};
		end
	end

	assign busy = 1'b0;
	assign done = vld_q[VLD_LEN-1];

	// command transfer register
	logic [2:0][31:0] wave_s0;
	logic [31:0] angle_s0;

	always_ff @(posedge clk) begin
		if (start) begin
			wave_s0 <= {wave_z, wave_y, wave_x};
			angle_s0 <= turn_angle;
		end
	end

	// ---------------- angle reduction and CORDIC ----------------
	logic [12:0] crd_v_s1;
	logic [18:0] crd_lo_s1;
	logic [23:0] crd_prod_s1;
	logic [24:0] crd_rpos_s2;
	logic [24:0] crd_w_s3;
	cr_t crd_in_s4;
	cr_t crd_c [CRD_STEPS+1];
	logic [33:0] crd_rx_s5;
	logic [33:0] crd_ry_s5;
	logic crd_nx_s5;
	logic crd_ny_s5;
	logic [31:0] cos_s6;
	logic [31:0] sin_s6;

	logic [7:0] crd_q0;
	logic [12:0] crd_rm;
	logic [5:0] crd_r45;
	logic [25:0] crd_d;
	logic signed [25:0] crd_r;
	logic crd_flip;
	logic [43:0] crd_xm;
	logic [43:0] crd_ym;
	logic [43:0] crd_xr;
	logic [43:0] crd_yr;
	logic [31:0] crd_cs;
	logic [31:0] crd_sn;

	always_comb begin
		crd_q0 = crd_prod_s1[23:16];
		crd_rm = crd_v_s1 - 13'(crd_q0 * BLOCK_45);
		if (crd_rm[6:0] >= 7'(BLOCK_45)) begin
			crd_r45 = 6'(crd_rm[6:0] - 7'(BLOCK_45));
		end else begin
			crd_r45 = crd_rm[5:0];
		end
		crd_d = {1'b0, crd_rpos_s2} - {1'b0, DEG_OFFSET};
	end

	// fold into [-90, 90] degrees, negating the result for the middle half
	always_comb begin
		crd_flip = 1'b0;
		if (crd_w_s3 > DEG_QUARTER && crd_w_s3 < DEG_3QUARTER) begin
			crd_r = $signed({1'b0, crd_w_s3}) - $signed({1'b0, DEG_HALF});
			crd_flip = 1'b1;
		end else if (crd_w_s3 >= DEG_3QUARTER) begin
			crd_r = $signed({1'b0, crd_w_s3}) - $signed({1'b0, DEG_FULL});
		end else begin
			crd_r = $signed({1'b0, crd_w_s3});
		end
	end

	always_ff @(posedge clk) begin
		// offset by 2^31, then split off the power of two in the modulus
		crd_v_s1 <= {~angle_s0[31], angle_s0[30:19]};
		crd_lo_s1 <= angle_s0[18:0];
		crd_prod_s1 <= 24'({~angle_s0[31], angle_s0[30:19]}) * 24'(RECIP_45);
		crd_rpos_s2 <= {crd_r45, crd_lo_s1};
		if (crd_d[25]) begin
			crd_w_s3 <= 25'(crd_d + {1'b0, DEG_FULL});
		end else begin
			crd_w_s3 <= crd_d[24:0];
		end
		crd_in_s4.x <= CRD_GAIN;
		crd_in_s4.y <= 44'd0;
		crd_in_s4.z <= {crd_r, 16'd0};
		crd_in_s4.flip <= crd_flip;
	end

	assign crd_c[0] = crd_in_s4;

	for (genvar k = 0; k < CRD_STEPS; k++) begin : g_crd
		tbw_cordic_cell u_cell (
			.clk(clk),
			.step(STEP_W'(k)),
			.cin(crd_c[k]),
			.cout(crd_c[k+1])
		);
	end

	always_comb begin
		crd_xm = crd_c[CRD_STEPS].x[43] ? (44'd0 - crd_c[CRD_STEPS].x) : crd_c[CRD_STEPS].x;
		crd_ym = crd_c[CRD_STEPS].y[43] ? (44'd0 - crd_c[CRD_STEPS].y) : crd_c[CRD_STEPS].y;
		crd_xr = crd_xm + 44'd512;
		crd_yr = crd_ym + 44'd512;
		crd_cs = (crd_rx_s5 > {2'b00, ONE_Q30}) ? ONE_Q30 : crd_rx_s5[31:0];
		crd_sn = (crd_ry_s5 > {2'b00, ONE_Q30}) ? ONE_Q30 : crd_ry_s5[31:0];
	end

	always_ff @(posedge clk) begin
		crd_rx_s5 <= crd_xr[43:10];
		crd_ry_s5 <= crd_yr[43:10];
		crd_nx_s5 <= crd_c[CRD_STEPS].x[43] ^ crd_c[CRD_STEPS].flip;
		crd_ny_s5 <= crd_c[CRD_STEPS].y[43] ^ crd_c[CRD_STEPS].flip;
		cos_s6 <= crd_nx_s5 ? (32'd0 - crd_cs) : crd_cs;
		sin_s6 <= crd_ny_s5 ? (32'd0 - crd_sn) : crd_sn;
	end

	// ---------------- first normalizer: k_hat ----------------
	logic [2:0][63:0] nk_in;
	logic [2:0][31:0] k_vec;
	logic k_ok;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			nk_in[j] = {{32{wave_s0[j][31]}}, wave_s0[j]};
		end
	end

	tbw_nrm u_nrm_k (
		.clk(clk),
		.vec_in(nk_in),
		.vec_out(k_vec),
		.vec_ok(k_ok)
	);

	// ---------------- e1 before normalization ----------------
	logic signed [63:0] e1p_xz_s1;
	logic signed [63:0] e1p_yz_s1;
	logic signed [63:0] e1p_zz_s1;
	logic e1p_fb_s1;
	logic [2:0][63:0] e1p_vec_s2;
	logic [31:0] kz_mag;

	assign kz_mag = k_vec[2][31] ? (32'd0 - k_vec[2]) : k_vec[2];

	always_ff @(posedge clk) begin
		e1p_xz_s1 <= $signed(k_vec[2]) * $signed(k_vec[0]);
		e1p_yz_s1 <= $signed(k_vec[2]) * $signed(k_vec[1]);
		e1p_zz_s1 <= $signed(k_vec[2]) * $signed(k_vec[2]);
		e1p_fb_s1 <= (kz_mag >= {1'b0, limit_q});
		// x axis fallback normalizes to itself exactly
		if (e1p_fb_s1) begin
			e1p_vec_s2 <= {64'd0, 64'd0, 64'd1 << 30};
		end else begin
			e1p_vec_s2[0] <= 64'd0 - e1p_xz_s1;
			e1p_vec_s2[1] <= 64'd0 - e1p_yz_s1;
			e1p_vec_s2[2] <= (64'd1 << 60) - e1p_zz_s1;
		end
	end

	logic [2:0][31:0] e1_vec;
	logic e1_ok;

	tbw_nrm u_nrm_e1 (
		.clk(clk),
		.vec_in(e1p_vec_s2),
		.vec_out(e1_vec),
		.vec_ok(e1_ok)
	);

	// ---------------- cross product ----------------
	logic [2:0][31:0] k_dl [K_DLY];
	logic err1_dl [K_DLY];
	logic [2:0][31:0] kd;

	always_ff @(posedge clk) begin
		k_dl[0] <= k_vec;
		err1_dl[0] <= ~k_ok;
		for (int i = 1; i < K_DLY; i++) begin
			k_dl[i] <= k_dl[i-1];
			err1_dl[i] <= err1_dl[i-1];
		end
	end

	assign kd = k_dl[K_DLY-1];

	logic signed [63:0] cx_a_s1;
	logic signed [63:0] cx_b_s1;
	logic signed [63:0] cy_a_s1;
	logic signed [63:0] cy_b_s1;
	logic signed [63:0] cz_a_s1;
	logic signed [63:0] cz_b_s1;
	status_t st2_s1;
	logic [2:0][63:0] cr_vec_s2;

	always_ff @(posedge clk) begin
		cx_a_s1 <= $signed(kd[1]) * $signed(e1_vec[2]);
		cx_b_s1 <= $signed(kd[2]) * $signed(e1_vec[1]);
		cy_a_s1 <= $signed(kd[2]) * $signed(e1_vec[0]);
		cy_b_s1 <= $signed(kd[0]) * $signed(e1_vec[2]);
		cz_a_s1 <= $signed(kd[0]) * $signed(e1_vec[1]);
		cz_b_s1 <= $signed(kd[1]) * $signed(e1_vec[0]);
		if (err1_dl[K_DLY-1]) begin
			st2_s1 <= ST_ZERO_WAVE;
		end else if (!e1_ok) begin
			st2_s1 <= ST_FIRST_DEGEN;
		end else begin
			st2_s1 <= ST_OK;
		end
		cr_vec_s2[0] <= cx_a_s1 - cx_b_s1;
		cr_vec_s2[1] <= cy_a_s1 - cy_b_s1;
		cr_vec_s2[2] <= cz_a_s1 - cz_b_s1;
	end

	logic [2:0][31:0] e2_vec;
	logic e2_ok;

	tbw_nrm u_nrm_e2 (
		.clk(clk),
		.vec_in(cr_vec_s2),
		.vec_out(e2_vec),
		.vec_ok(e2_ok)
	);

	// ---------------- rotation and output ----------------
	logic [2:0][31:0] e1_dl [K_DLY];
	status_t st_dl [ST_DLY];
	logic [63:0] cs_dl [CS_DLY];
	logic [2:0][31:0] e1d;
	status_t st2d;
	logic signed [31:0] cd;
	logic signed [31:0] sd;

	always_ff @(posedge clk) begin
		e1_dl[0] <= e1_vec;
		for (int i = 1; i < K_DLY; i++) begin
			e1_dl[i] <= e1_dl[i-1];
		end
		st_dl[0] <= st2_s1;
		for (int i = 1; i < ST_DLY; i++) begin
			st_dl[i] <= st_dl[i-1];
		end
		cs_dl[0] <= {sin_s6, cos_s6};
		for (int i = 1; i < CS_DLY; i++) begin
			cs_dl[i] <= cs_dl[i-1];
		end
	end

	assign e1d = e1_dl[K_DLY-1];
	assign st2d = st_dl[ST_DLY-1];
	assign cd = $signed(cs_dl[CS_DLY-1][31:0]);
	assign sd = $signed(cs_dl[CS_DLY-1][63:32]);

	logic signed [63:0] ce1_s1 [3];
	logic signed [63:0] se2_s1 [3];
	logic signed [63:0] ce2_s1 [3];
	logic signed [63:0] se1_s1 [3];
	status_t st3_s1;
	status_t st3_s2;
	logic [63:0] v1_s2 [3];
	logic [63:0] v2_s2 [3];

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			ce1_s1[j] <= cd * $signed(e1d[j]);
			se2_s1[j] <= sd * $signed(e2_vec[j]);
			ce2_s1[j] <= cd * $signed(e2_vec[j]);
			se1_s1[j] <= sd * $signed(e1d[j]);
			v1_s2[j] <= ce1_s1[j] + se2_s1[j];
			v2_s2[j] <= ce2_s1[j] - se1_s1[j];
		end
		if (st2d != ST_OK) begin
			st3_s1 <= st2d;
		end else if (!e2_ok) begin
			st3_s1 <= ST_SECOND_DEGEN;
		end else begin
			st3_s1 <= ST_OK;
		end
		st3_s2 <= st3_s1;
	end

	always_ff @(posedge clk) begin
		status <= st3_s2;
		if (st3_s2 != ST_OK) begin
			first_x <= 32'sd0;
			first_y <= 32'sd0;
			first_z <= 32'sd0;
			second_x <= 32'sd0;
			second_y <= 32'sd0;
			second_z <= 32'sd0;
		end else begin
			first_x <= q30_round(v1_s2[0]);
			first_y <= q30_round(v1_s2[1]);
			first_z <= q30_round(v1_s2[2]);
			second_x <= q30_round(v2_s2[0]);
			second_y <= q30_round(v2_s2[1]);
			second_z <= q30_round(v2_s2[2]);
		end
	end

endmodule
